[src/point_in_polygon_winding_top_macros.svh]
// assertion macros for the checker file
`ifndef POINT_IN_POLYGON_WINDING_TOP_MACROS_SVH
`define POINT_IN_POLYGON_WINDING_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pip check failed");

`endif

[src/pip_pkg.sv]
package pip_pkg;

  localparam int CoordWidth  = 16;
  localparam int IdxWidth    = 6;
  localparam int CountWidth  = 7;
  localparam int MaxVertices = 64;
  localparam int ProdWidth   = 2 * CoordWidth + 2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;

  typedef struct packed {
    logic                cmd;
    logic [IdxWidth-1:0] vertex_index;
    coord_t              coord_x;
    coord_t              coord_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } out_item_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  // partial result of one edge, finished by the next cell
  typedef struct packed {
    logic  act;
    logic  bbox;
    logic  up;
    logic  dn;
    prod_t l;
    prod_t r;
  } pend_t;

  typedef struct packed {
    logic   vld;
    coord_t px;
    coord_t py;
    logic   on;
    pend_t  pend;
  } token_t;

  typedef struct packed {
    logic on;
    logic inc;
    logic dec;
  } edge_res_t;

  function automatic edge_res_t resolve_edge(input pend_t p);
    edge_res_t res;
    res.on  = p.act && p.bbox && (p.l == p.r);
    res.inc = p.act && p.up && (p.l > p.r);
    res.dec = p.act && p.dn && (p.l < p.r);
    return res;
  endfunction

endpackage

[src/pip_cell.sv]
module pip_cell #(
  parameter int CELL_INDEX   = 0,
  parameter int MAX_VERTICES = pip_pkg::MaxVertices,
  parameter int WN_WIDTH     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [pip_pkg::CountWidth-1:0] cnt,
  input  logic                           load_en,
  input  logic [pip_pkg::IdxWidth-1:0]   load_idx,
  input  pip_pkg::vertex_t               load_vtx,
  input  pip_pkg::vertex_t               v_next,
  input  pip_pkg::vertex_t               v_first,
  output pip_pkg::vertex_t               vtx_out,
  input  pip_pkg::token_t                tok_in,
  input  logic signed [WN_WIDTH-1:0]     wn_in,
  output pip_pkg::token_t                tok_out,
  output logic signed [WN_WIDTH-1:0]     wn_out
);
  import pip_pkg::*;

  localparam bit IsEnd = (CELL_INDEX == MAX_VERTICES - 1);

  vertex_t                     vtx_r;
  token_t                      tok_r;
  token_t                      tok_nxt;
  logic signed [WN_WIDTH-1:0]  wn_r;
  logic signed [WN_WIDTH-1:0]  wn_nxt;
  logic                        active;
  logic                        last;
  vertex_t                     b;
  logic signed [CoordWidth:0]  dx;
  logic signed [CoordWidth:0]  dy;
  logic signed [CoordWidth:0]  dpx;
  logic signed [CoordWidth:0]  dpy;
  edge_res_t                   res;

  // own vertex slot
  always_ff @(posedge clk) begin
    if (load_en && (int'(load_idx) == CELL_INDEX)) begin
      vtx_r <= load_vtx;
    end
  end

  assign active = int'(cnt) > CELL_INDEX;
  assign last   = active && (IsEnd || (int'(cnt) == CELL_INDEX + 1));
  assign b      = last ? v_first : v_next;

  always_comb begin
    dx  = {b.x[CoordWidth-1], b.x} - {vtx_r.x[CoordWidth-1], vtx_r.x};
    dy  = {b.y[CoordWidth-1], b.y} - {vtx_r.y[CoordWidth-1], vtx_r.y};
    dpx = {tok_in.px[CoordWidth-1], tok_in.px} - {vtx_r.x[CoordWidth-1], vtx_r.x};
    dpy = {tok_in.py[CoordWidth-1], tok_in.py} - {vtx_r.y[CoordWidth-1], vtx_r.y};
    res = resolve_edge(tok_in.pend);

    tok_nxt.vld       = tok_in.vld;
    tok_nxt.px        = tok_in.px;
    tok_nxt.py        = tok_in.py;
    tok_nxt.on        = tok_in.on || res.on;
    tok_nxt.pend.act  = active;
    tok_nxt.pend.bbox = ((vtx_r.x <= tok_in.px && tok_in.px <= b.x) ||
                         (b.x <= tok_in.px && tok_in.px <= vtx_r.x)) &&
                        ((vtx_r.y <= tok_in.py && tok_in.py <= b.y) ||
                         (b.y <= tok_in.py && tok_in.py <= vtx_r.y));
    tok_nxt.pend.up   = (vtx_r.y <= tok_in.py) && (b.y > tok_in.py);
    tok_nxt.pend.dn   = (vtx_r.y > tok_in.py) && (b.y <= tok_in.py);
    tok_nxt.pend.l    = dx * dpy;
    tok_nxt.pend.r    = dy * dpx;

    if (res.inc) begin
      wn_nxt = wn_in + WN_WIDTH'(1);
    end else if (res.dec) begin
      wn_nxt = wn_in - WN_WIDTH'(1);
    end else begin
      wn_nxt = wn_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      wn_r  <= wn_nxt;
    end
  end

  assign vtx_out = vtx_r;
  assign tok_out = tok_r;
  assign wn_out  = wn_r;

endmodule

[src/point_in_polygon_winding_top.sv]
// Winding-number point-in-polygon test over a polygon of up to MAX_VERTICES
// vertices held one per cell in a chain of cells. A load item (cmd 0) writes
// one vertex and gives no result; loads run back to back. A query item (cmd 1)
// gives one result: its point walks the chain one cell per cycle while the
// chain is not held, through every cell whatever vertex_count is, and its
// result is then loaded into the output register. in_stall stays high from
// the cycle after a query's acceptance until its result is in the output
// register, then the next item is taken while that result waits. The user
// must write vertex_count through cfg_wr_en / cfg_wr_data only while idle;
// the block does not enforce it. Vertex slots are not cleared by reset and
// must be loaded before a query uses them; there is no clearing pass.
module point_in_polygon_winding_top #(
  parameter int MAX_VERTICES = pip_pkg::MaxVertices
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pip_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pip_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [pip_pkg::CountWidth-1:0] cfg_wr_data
);
  import pip_pkg::*;

  // winding number spans -MAX_VERTICES..MAX_VERTICES
  localparam int WnWidth = $clog2(MAX_VERTICES + 1) + 1;

  logic [CountWidth-1:0]       count_r;
  logic                        busy_r;
  logic                        busy_nxt;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  out_item_t                   out_r;
  out_item_t                   out_nxt;

  logic                        accept;
  logic                        load_en;
  logic                        adv;
  logic                        out_load;
  vertex_t                     load_vtx;
  vertex_t                     vert [MAX_VERTICES];
  token_t                      tok  [MAX_VERTICES+1];
  logic signed [WnWidth-1:0]   wn   [MAX_VERTICES+1];
  edge_res_t                   tail_res;
  logic signed [WnWidth-1:0]   wn_fin;

  // one query in flight at a time
  assign in_stall = busy_r;
  assign accept   = in_valid && !in_stall;
  assign load_en  = accept && (in_data.cmd == CmdLoad);

  assign load_vtx.x = in_data.coord_x;
  assign load_vtx.y = in_data.coord_y;

  // the chain holds still only while a result waits at its end
  assign adv      = !(tok[MAX_VERTICES].vld && out_vld_r && out_stall);
  assign out_load = tok[MAX_VERTICES].vld && adv;

  // query token entering the first cell, no edge pending yet
  always_comb begin
    tok[0]      = '0;
    tok[0].vld  = accept && (in_data.cmd == CmdQuery);
    tok[0].px   = in_data.coord_x;
    tok[0].py   = in_data.coord_y;
    wn[0]       = '0;
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    // the end of the chain wraps its next vertex to the first slot
    vertex_t v_next;
    if (k == MAX_VERTICES - 1) begin : g_wrap
      assign v_next = vert[0];
    end else begin : g_link
      assign v_next = vert[k+1];
    end

    pip_cell #(
      .CELL_INDEX  (k),
      .MAX_VERTICES(MAX_VERTICES),
      .WN_WIDTH    (WnWidth)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cnt     (count_r),
      .load_en (load_en),
      .load_idx(in_data.vertex_index),
      .load_vtx(load_vtx),
      .v_next  (v_next),
      .v_first (vert[0]),
      .vtx_out (vert[k]),
      .tok_in  (tok[k]),
      .wn_in   (wn[k]),
      .tok_out (tok[k+1]),
      .wn_out  (wn[k+1])
    );
  end

  // finish the last edge carried out of the chain
  always_comb begin
    tail_res = resolve_edge(tok[MAX_VERTICES].pend);
    if (tail_res.inc) begin
      wn_fin = wn[MAX_VERTICES] + WnWidth'(1);
    end else if (tail_res.dec) begin
      wn_fin = wn[MAX_VERTICES] - WnWidth'(1);
    end else begin
      wn_fin = wn[MAX_VERTICES];
    end
    out_nxt.on_boundary = tok[MAX_VERTICES].on || tail_res.on;
    out_nxt.inside_res  = out_nxt.on_boundary || (wn_fin != '0);
  end

  // busy from query accept until its result is in the output register
  always_comb begin
    busy_nxt = busy_r;
    if (tok[0].vld) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
    out_vld_nxt = (out_vld_r && out_stall) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[src/pip_checker.sv]
module pip_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input pip_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input pip_pkg::out_item_t             out_data
);
  import pip_pkg::*;

`include "point_in_polygon_winding_top_macros.svh"

  // a stalled result holds
  `PIP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a boundary point is always inside
  `PIP_ASSERT_IMP(a_on_inside, out_valid && out_data.on_boundary, out_data.inside_res)

  // an accepted query blocks the input next cycle
  `PIP_ASSERT_NXT(a_query_busy, in_valid && !in_stall && (in_data.cmd == CmdQuery), in_stall)

  // a load never brings a result
  `PIP_ASSERT_NXT(a_load_quiet, in_valid && !in_stall && (in_data.cmd == CmdLoad) && !out_valid, !out_valid)

endmodule

bind point_in_polygon_winding_top pip_checker u_pip_checker (.*);
